// File: hdl/eight_bit_cpu_execute_unit_macros.svh
// Assertion macros for the execute unit.
`ifndef EIGHT_BIT_CPU_EXECUTE_UNIT_MACROS_SVH
`define EIGHT_BIT_CPU_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTH
`define ECU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ecu assertion failed");
`define ECU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ecu assertion failed");
`else
`define ECU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ECU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/ecu_pkg.sv
// Shared types and constants of the execute unit.
package ecu_pkg;

    localparam int IDX_W       = 6;
    localparam int IDX_N       = 1 << IDX_W;
    localparam int DATA_W      = 8;
    localparam int PC_W        = 16;
    localparam int FLAG_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam int FLAG_Z = 0;
    localparam int FLAG_S = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;
    localparam int FLAG_C = 4;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_MOVI = 4'd3,
        OP_BEQZ = 4'd4,
        OP_ANDI = 4'd5,
        OP_EOR  = 4'd6,
        OP_BR   = 4'd7,
        OP_SAL  = 4'd8,
        OP_SAR  = 4'd9,
        OP_LDR  = 4'd10,
        OP_STR  = 4'd11
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             reg_wr;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        logic [IDX_W-1:0] imm;
        logic [PC_W-1:0]  pc;
    } t_dec;

endpackage

// File: hdl/ecu_front.sv
// Front end: accepts instructions, wraps register indexes and classifies the opcode.
module ecu_front import ecu_pkg::*; #(
    parameter int REG_COUNT = 64
) (
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_instruction_word,
    input  logic [15:0] i_instr_pc,
    input  logic        i_q_full,
    output logic        o_push,
    output t_dec        o_dec
);

    localparam int OP_LSB = 12;
    localparam int RA_LSB = 6;

    logic [IDX_W-1:0] w_wrap [IDX_N];
    t_op              w_op;

    for (genvar gi = 0; gi < IDX_N; gi++) begin : g_wrap
        assign w_wrap[gi] = IDX_W'(gi % REG_COUNT);
    end

    assign w_op       = t_op'(i_instruction_word[OP_LSB +: 4]);
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_dec.op  = w_op;
        o_dec.ra  = w_wrap[i_instruction_word[RA_LSB +: IDX_W]];
        o_dec.rb  = w_wrap[i_instruction_word[IDX_W-1:0]];
        o_dec.imm = i_instruction_word[IDX_W-1:0];
        o_dec.pc  = i_instr_pc;
        case (w_op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_MOVI, OP_ANDI, OP_EOR,
            OP_SAL, OP_SAR, OP_LDR: o_dec.reg_wr = 1'b1;
            default:                o_dec.reg_wr = 1'b0;
        endcase
    end

endmodule

// File: hdl/ecu_fifo.sv
// Two-entry queue of decoded instructions between front and back end.
module ecu_fifo import ecu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_dec i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_dec o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_dec          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hdl/ecu_back.sv
// Back end: register file and data store reads, execute, write-back and result register.
module ecu_back import ecu_pkg::*; #(
    parameter int REG_COUNT = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    output logic                     o_q_pop,
    input  t_dec                     i_dec,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_redirect,
    output logic [PC_W-1:0]          o_branch_target,
    output logic                     o_reg_write,
    output logic [IDX_W-1:0]         o_reg_index,
    output logic signed [DATA_W-1:0] o_reg_value,
    output logic [FLAG_W-1:0]        o_flags
);

    localparam int RW      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int SHIFT_W = 3;

    // the store is only ever addressed by the 6-bit immediate, so 64 entries are reachable
    logic [DATA_W-1:0]    r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [DATA_W-1:0]    r_ds [IDX_N];
    logic [IDX_N-1:0]     r_ds_vld;

    logic              r_x_vld;
    t_dec              r_x;
    logic [DATA_W-1:0] r_a_raw, r_b_raw, r_m_raw;
    logic              r_a_ok, r_b_ok, r_m_ok;

    logic              r_fw_en;
    logic [RW-1:0]     r_fw_idx;
    logic [DATA_W-1:0] r_fw_val;
    logic              r_sfw_en;
    logic [IDX_W-1:0]  r_sfw_idx;
    logic [DATA_W-1:0] r_sfw_val;

    logic [FLAG_W-1:0] r_flags;

    logic              r_o_vld;
    logic              r_o_br;
    logic [PC_W-1:0]   r_o_tgt;
    logic              r_o_wr;
    logic [IDX_W-1:0]  r_o_idx;
    logic [DATA_W-1:0] r_o_val;
    logic [FLAG_W-1:0] r_o_flags;

    logic              w_commit, w_adv;
    logic [DATA_W-1:0] w_a, w_b, w_m, w_imm_s, w_res;
    logic [DATA_W:0]   w_sum;
    logic [2*DATA_W-1:0] w_prod;
    logic [SHIFT_W-1:0] w_sh;
    logic              w_big;
    logic              w_br;
    logic [PC_W-1:0]   w_tgt;
    logic [FLAG_W-1:0] w_flags;

    function automatic logic [FLAG_W-1:0] zn_of(input logic [DATA_W-1:0] v);
        logic [FLAG_W-1:0] f;
        f         = '0;
        f[FLAG_Z] = (v == '0);
        f[FLAG_N] = v[DATA_W-1];
        return f;
    endfunction

    assign w_commit = r_x_vld && (!r_o_vld || i_out_ready);
    assign w_adv    = !r_x_vld || w_commit;
    assign o_q_pop  = i_q_valid && w_adv;

    assign w_a = (r_fw_en && r_fw_idx == r_x.ra[RW-1:0]) ? r_fw_val :
                 (r_a_ok ? r_a_raw : '0);
    assign w_b = (r_fw_en && r_fw_idx == r_x.rb[RW-1:0]) ? r_fw_val :
                 (r_b_ok ? r_b_raw : '0);
    assign w_m = (r_sfw_en && r_sfw_idx == r_x.imm) ? r_sfw_val :
                 (r_m_ok ? r_m_raw : '0);

    assign w_imm_s = {{(DATA_W - IDX_W){r_x.imm[IDX_W-1]}}, r_x.imm};
    assign w_sh    = r_x.imm[SHIFT_W-1:0];
    assign w_big   = (r_x.imm[IDX_W-1:SHIFT_W] != '0);
    assign w_prod  = (2*DATA_W)'(w_a) * (2*DATA_W)'(w_b);

    always_comb begin
        w_res   = '0;
        w_br    = 1'b0;
        w_tgt   = '0;
        w_flags = r_flags;
        w_sum   = '0;
        case (r_x.op)
            OP_ADD: begin
                w_sum           = {1'b0, w_a} + {1'b0, w_b};
                w_res           = w_sum[DATA_W-1:0];
                w_flags         = zn_of(w_res);
                w_flags[FLAG_C] = w_sum[DATA_W];
                w_flags[FLAG_V] = ~(w_a[DATA_W-1] ^ w_b[DATA_W-1])
                                & (w_a[DATA_W-1] ^ w_res[DATA_W-1]);
            end
            OP_SUB: begin
                w_res           = w_a - w_b;
                w_flags         = zn_of(w_res);
                w_flags[FLAG_V] = (w_a[DATA_W-1] ^ w_b[DATA_W-1])
                                & ~(w_res[DATA_W-1] ^ w_b[DATA_W-1]);
            end
            OP_MUL: begin
                w_res   = w_prod[DATA_W-1:0];
                w_flags = zn_of(w_res);
            end
            OP_MOVI: begin
                w_res = w_imm_s;
            end
            OP_BEQZ: begin
                if (w_a == '0) begin
                    w_br  = 1'b1;
                    w_tgt = r_x.pc + PC_W'(1) + PC_W'(r_x.imm);
                end
            end
            OP_ANDI: begin
                w_res   = w_a & w_imm_s;
                w_flags = zn_of(w_res);
            end
            OP_EOR: begin
                w_res   = w_a ^ w_b;
                w_flags = zn_of(w_res);
            end
            OP_BR: begin
                w_br  = 1'b1;
                w_tgt = {2'b00, w_a, {IDX_W{1'b0}}} | {{(PC_W - DATA_W){1'b0}}, w_b};
            end
            OP_SAL: begin
                w_res   = w_big ? '0 : (w_a << w_sh);
                w_flags = zn_of(w_res);
            end
            OP_SAR: begin
                w_res   = w_big ? {DATA_W{w_a[DATA_W-1]}}
                                : DATA_W'($signed(w_a) >>> w_sh);
                w_flags = zn_of(w_res);
            end
            OP_LDR: begin
                w_res = w_m;
            end
            OP_STR: begin
                w_res = '0;
            end
            default: begin
                w_res = '0;
            end
        endcase
        w_flags[FLAG_S] = w_flags[FLAG_S] | (w_flags[FLAG_N] ^ w_flags[FLAG_V]);
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_raw <= r_rf[i_dec.ra[RW-1:0]];
            r_b_raw <= r_rf[i_dec.rb[RW-1:0]];
            r_m_raw <= r_ds[i_dec.imm];
        end
        if (w_commit && r_x.reg_wr) begin
            r_rf[r_x.ra[RW-1:0]] <= w_res;
        end
        if (w_commit && r_x.op == OP_STR) begin
            r_ds[r_x.imm] <= w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_x    <= i_dec;
            r_a_ok <= r_rf_vld[i_dec.ra[RW-1:0]];
            r_b_ok <= r_rf_vld[i_dec.rb[RW-1:0]];
            r_m_ok <= r_ds_vld[i_dec.imm];
        end
        if (w_commit && r_x.reg_wr) begin
            r_fw_idx <= r_x.ra[RW-1:0];
            r_fw_val <= w_res;
        end
        if (w_commit && r_x.op == OP_STR) begin
            r_sfw_idx <= r_x.imm;
            r_sfw_val <= w_a;
        end
        if (w_commit) begin
            r_o_br    <= w_br;
            r_o_tgt   <= w_tgt;
            r_o_wr    <= r_x.reg_wr;
            r_o_idx   <= r_x.reg_wr ? r_x.ra : '0;
            r_o_val   <= r_x.reg_wr ? w_res : '0;
            r_o_flags <= w_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
            r_rf_vld <= '0;
            r_ds_vld <= '0;
            r_fw_en  <= 1'b0;
            r_sfw_en <= 1'b0;
            r_flags  <= '0;
        end else begin
            if (w_adv) begin
                r_x_vld <= i_q_valid;
            end
            if (w_commit) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            if (w_commit) begin
                r_flags <= w_flags;
                if (r_x.reg_wr) begin
                    r_rf_vld[r_x.ra[RW-1:0]] <= 1'b1;
                    r_fw_en                  <= 1'b1;
                end
                if (r_x.op == OP_STR) begin
                    r_ds_vld[r_x.imm] <= 1'b1;
                    r_sfw_en          <= 1'b1;
                end
            end
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_redirect      = r_o_br;
    assign o_branch_target = r_o_tgt;
    assign o_reg_write     = r_o_wr;
    assign o_reg_index     = r_o_idx;
    assign o_reg_value     = $signed(r_o_val);
    assign o_flags         = r_o_flags;

endmodule

// File: hdl/eight_bit_cpu_execute_unit.sv
// Top level of the 8-bit CPU execute unit: front end, queue and back end.
//
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_instruction_word, i_instr_pc
// output  | out       | o_out_valid / i_out_ready  | o_redirect .. o_flags
//
// One instruction per cycle sustained while i_out_ready does not stall the output.
// An input passes through the queue register, the registered register-file read and the result register.
// Write-back forwarding covers back-to-back register and store dependences.
// Synchronous reset clears the queue, pipeline, status and the valid bits of both stores.
// An output stall fills the result register, then the back end, then the two-entry queue.
`include "eight_bit_cpu_execute_unit_macros.svh"
module eight_bit_cpu_execute_unit import ecu_pkg::*; #(
    parameter int REG_COUNT = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [15:0]              i_instruction_word,
    input  logic [15:0]              i_instr_pc,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_redirect,
    output logic [15:0]              o_branch_target,
    output logic                     o_reg_write,
    output logic [5:0]               o_reg_index,
    output logic signed [7:0]        o_reg_value,
    output logic [4:0]               o_flags
);

    logic w_push, w_full, w_q_valid, w_pop;
    t_dec w_dec_in, w_dec_out;

    ecu_front #(.REG_COUNT(REG_COUNT)) u_front (
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_instruction_word (i_instruction_word),
        .i_instr_pc         (i_instr_pc),
        .i_q_full           (w_full),
        .o_push             (w_push),
        .o_dec              (w_dec_in)
    );

    ecu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_dec_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_dec_out)
    );

    ecu_back #(.REG_COUNT(REG_COUNT)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .o_q_pop         (w_pop),
        .i_dec           (w_dec_out),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_redirect      (o_redirect),
        .o_branch_target (o_branch_target),
        .o_reg_write     (o_reg_write),
        .o_reg_index     (o_reg_index),
        .o_reg_value     (o_reg_value),
        .o_flags         (o_flags)
    );

    `ECU_ASSERT_IMPLIES(a_pop_needs_entry, i_clk, i_rst_n, w_pop, w_q_valid)
    `ECU_ASSERT_IMPLIES(a_accept_pushes, i_clk, i_rst_n, i_in_valid && o_in_ready, w_push)
    `ECU_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, w_q_valid)

endmodule
